// ===== rtl/core/vkpt_pkg.sv =====
// Package for the versioned keyed position table.
// Holds function codes, status codes, controller states and command/status structs.
package vkpt_pkg;

    typedef enum logic [1:0] {
        FUNC_UPSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_VALUE  = 2'd2,
        FUNC_UNDEF  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_OLDER   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_ACCUM,
        S_DONE
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // capture request, clear scan state
        logic rd_next;    // advance scan index
        logic mult;       // register product
        logic accum;      // add product into total
        logic hit_take;   // latch match at current index
        logic write;      // write entry, bump revision
        logic finish;     // form result into output register
    } vkpt_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic [1:0] func;
        logic       key_bad;
        logic       scan_end;
        logic       match_both;
        logic       match_acct;
        logic       full;
        logic       older;
    } vkpt_sts_t;

    localparam int ENTRY_W = 64 + 64 + 24 + 32 + 32 + 32;

endpackage

// ===== rtl/core/versioned_keyed_position_table.sv =====
// Top level of the versioned keyed position table: controller plus datapath.
// Each scanned entry passes S_READ and S_CHECK, a summed entry also S_ACCUM; the scan ends
// in S_DONE, which forms the result register; one request at a time.
// A new request is accepted only once the last result has been taken; the pace is set by
// the one-entry RAM scan, the multiply and add stages and the result handshake.
// Reset clears entry count to 0 and revision to 1; entry storage is not cleared.
module versioned_keyed_position_table
    import vkpt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [63:0] account_key,
    input  logic [63:0] instrument_key,
    input  logic [23:0] currency_code,
    input  logic [31:0] source_version,
    input  logic signed [31:0] quantity_in,
    input  logic [31:0] price_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        found,
    output logic [31:0] found_version,
    output logic signed [31:0] found_quantity,
    output logic [31:0] found_price,
    output logic [23:0] found_currency,
    output logic [31:0] table_revision,
    output logic signed [63:0] total_value
);
    vkpt_cmd_t cmd;
    vkpt_sts_t sts;

    // The controller walks entries one RAM read at a time.
    vkpt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .sts(sts), .cmd(cmd)
    );

    // The datapath holds the table, the scan index and the result register.
    vkpt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .func(func), .account_key(account_key), .instrument_key(instrument_key),
        .currency_code(currency_code), .source_version(source_version),
        .quantity_in(quantity_in), .price_in(price_in),
        .status(status), .found(found), .found_version(found_version),
        .found_quantity(found_quantity), .found_price(found_price),
        .found_currency(found_currency), .table_revision(table_revision),
        .total_value(total_value)
    );
endmodule

// ===== rtl/core/vkpt_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module vkpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/vkpt_datapath.sv =====
// Datapath: request registers, entry RAM, scan index, multiply-accumulate, result register.
// Depends on vkpt_pkg and vkpt_ram.
module vkpt_datapath
    import vkpt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  vkpt_cmd_t   cmd,
    output vkpt_sts_t   sts,
    input  logic [1:0]  func,
    input  logic [63:0] account_key,
    input  logic [63:0] instrument_key,
    input  logic [23:0] currency_code,
    input  logic [31:0] source_version,
    input  logic signed [31:0] quantity_in,
    input  logic [31:0] price_in,
    output logic [1:0]  status,
    output logic        found,
    output logic [31:0] found_version,
    output logic signed [31:0] found_quantity,
    output logic [31:0] found_price,
    output logic [23:0] found_currency,
    output logic [31:0] table_revision,
    output logic signed [63:0] total_value
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [1:0]  func_reg;
    logic [63:0] acct_reg, inst_reg;
    logic [23:0] cur_reg;
    logic [31:0] ver_reg, qty_reg, prc_reg;
    logic [CW-1:0] count_reg, idx_reg, hit_reg;
    logic        hit_valid_reg;
    logic [31:0] rev_reg;
    logic signed [63:0] prod_reg, total_reg;
    logic [ENTRY_W-1:0] rdata, wdata;
    logic [AW-1:0] raddr, waddr;

    logic [63:0] e_acct, e_inst;
    logic [23:0] e_cur;
    logic [31:0] e_ver, e_qty, e_prc;

    assign {e_acct, e_inst, e_cur, e_ver, e_qty, e_prc} = rdata;
    assign wdata = {acct_reg, inst_reg, cur_reg, ver_reg, qty_reg, prc_reg};
    assign raddr = idx_reg[AW-1:0];
    assign waddr = hit_valid_reg ? hit_reg[AW-1:0] : count_reg[AW-1:0];

    vkpt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk(clk), .we(cmd.write), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign sts.func       = func_reg;
    assign sts.key_bad    = (acct_reg == 64'd0) || (inst_reg == 64'd0) || (cur_reg == 24'd0);
    assign sts.scan_end   = (idx_reg >= count_reg);
    assign sts.match_both = (e_acct == acct_reg) && (e_inst == inst_reg);
    assign sts.match_acct = (e_acct == acct_reg);
    assign sts.full       = (count_reg == CW'(TABLE_DEPTH));
    assign sts.older      = (ver_reg < e_ver);

    logic signed [64:0] sum_wide;
    assign sum_wide = {total_reg[63], total_reg} + {prod_reg[63], prod_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            acct_reg <= account_key;
            inst_reg <= instrument_key;
            cur_reg  <= currency_code;
            ver_reg  <= source_version;
            qty_reg  <= quantity_in;
            prc_reg  <= price_in;
        end
        if (cmd.mult)
        begin
            prod_reg <= $signed(e_qty) * $signed({1'b0, e_prc});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rev_reg       <= 32'd1;
            idx_reg       <= '0;
            hit_reg       <= '0;
            hit_valid_reg <= 1'b0;
            total_reg     <= '0;
            status        <= ST_OK;
            found         <= 1'b0;
            found_version <= '0;
            found_quantity <= '0;
            found_price   <= '0;
            found_currency <= '0;
            table_revision <= 32'd1;
            total_value   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg       <= '0;
                hit_valid_reg <= 1'b0;
                total_reg     <= '0;
            end
            if (cmd.rd_next)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.hit_take)
            begin
                hit_reg       <= idx_reg;
                hit_valid_reg <= 1'b1;
            end
            if (cmd.accum)
            begin
                if (sum_wide[64] != sum_wide[63])
                    total_reg <= sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                else
                    total_reg <= sum_wide[63:0];
            end
            if (cmd.write)
            begin
                rev_reg <= rev_reg + 32'd1;
                if (!hit_valid_reg)
                    count_reg <= count_reg + CW'(1);
            end
            if (cmd.finish)
            begin
                // Status follows from the function code and the scan outcome.
                found          <= 1'b0;
                found_version  <= '0;
                found_quantity <= '0;
                found_price    <= '0;
                found_currency <= '0;
                total_value    <= '0;
                table_revision <= cmd.write ? rev_reg + 32'd1 : rev_reg;
                case (func_reg)
                    FUNC_UPSERT:
                    begin
                        if (sts.key_bad)
                            status <= ST_INVALID;
                        else if (hit_valid_reg)
                            status <= (sts.older) ? ST_OLDER : ST_OK;
                        else if (sts.full)
                            status <= ST_FULL;
                        else
                            status <= ST_OK;
                    end
                    FUNC_LOOKUP:
                    begin
                        status <= ST_OK;
                        if (hit_valid_reg)
                        begin
                            found          <= 1'b1;
                            found_version  <= e_ver;
                            found_quantity <= e_qty;
                            found_price    <= e_prc;
                            found_currency <= e_cur;
                        end
                    end
                    FUNC_VALUE:
                    begin
                        status      <= ST_OK;
                        total_value <= total_reg;
                    end
                    default:
                    begin
                        status <= ST_INVALID;
                    end
                endcase
            end
        end
    end
endmodule

// ===== rtl/core/vkpt_ctrl.sv =====
// Controller state machine sequencing the scan, multiply, write and result.
// Depends on vkpt_pkg.
module vkpt_ctrl
    import vkpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  vkpt_sts_t sts,
    output vkpt_cmd_t cmd
);
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   hit_reg, hit_next;

    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hit_next       = hit_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    hit_next   = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // RAM address is idx_reg; data arrives next cycle.
                if (sts.scan_end || (sts.func == FUNC_UPSERT && sts.key_bad)
                    || sts.func == FUNC_UNDEF)
                    state_next = S_DONE;
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.func == FUNC_VALUE)
                begin
                    if (sts.match_acct)
                    begin
                        cmd.mult   = 1'b1;
                        state_next = S_ACCUM;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = S_READ;
                    end
                end
                else if (sts.match_both)
                begin
                    cmd.hit_take = 1'b1;
                    hit_next     = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_ACCUM:
            begin
                cmd.accum   = 1'b1;
                cmd.rd_next = 1'b1;
                state_next  = S_READ;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                if (sts.func == FUNC_UPSERT && !sts.key_bad
                    && (hit_reg ? !sts.older : !sts.full))
                    cmd.write = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
